/* hdl/kerg_pkg.sv */
// kerg_pkg: shared types and constants for the key event repeat generator
// used by kerg_mod and key_event_repeat_generator; depends on nothing else
package kerg_pkg;

    localparam int DATA_W       = 32;
    localparam int IN_KEYS      = 16;
    localparam int MASK_W       = 16;
    localparam int KEY_IDX_W    = 4;
    localparam int KIND_W       = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int STEP_W       = $clog2(DATA_W);
    localparam int DEF_NUM_KEYS = 16;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_PAUSE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLICK_LIMIT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_MASK  = 2'd3;

    // register reset values
    localparam logic [DATA_W-1:0] RST_REPEAT_DELAY = 32'd30;
    localparam logic [DATA_W-1:0] RST_REPEAT_PAUSE = 32'd8;
    localparam logic [DATA_W-1:0] RST_CLICK_LIMIT  = 32'd30;
    localparam logic [MASK_W-1:0] RST_IGNORE_MASK  = 16'h3000;

    typedef enum logic [KIND_W-1:0] {
        EV_DOWN   = 2'd0,
        EV_REPEAT = 2'd1,
        EV_UP     = 2'd2,
        EV_CLICK  = 2'd3
    } ev_kind_t;

    // request to the shared remainder unit
    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } mod_req_t;

    // answer from the shared remainder unit
    typedef struct packed {
        logic done;
        logic rem_zero;
    } mod_rsp_t;

endpackage

/* hdl/kerg_mod.sv */
// kerg_mod: iterative restoring remainder unit, one quotient bit per cycle
// depends on kerg_pkg for widths and the request/response structs
module kerg_mod
    import kerg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mod_req_t req,
    output mod_rsp_t rsp
);

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DATA_W - 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] dvd_reg, dvd_next;
    logic [DATA_W-1:0] div_reg, div_next;

    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   diff;

    // shift in next dividend bit, subtract when it fits
    assign trial = {rem_reg, dvd_reg[DATA_W-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            dvd_next  = req.dividend;
            div_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = (trial >= {1'b0, div_reg}) ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
            dvd_next  = {dvd_reg[DATA_W-2:0], 1'b0};
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        div_reg <= div_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.rem_zero = (rem_reg == '0);

    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("remainder unit started while busy");

    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("remainder unit done while still busy");

    a_last_step_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && step_reg == LAST_STEP && !req.start |=> done_reg)
        else $error("remainder unit missed its done pulse");

endmodule

/* hdl/key_event_repeat_generator.sv */
// key_event_repeat_generator: typematic repeat and click detection over a key bitmap
// depends on kerg_pkg and kerg_mod (shared remainder unit)
// output: events wait in a pending slot, then move to the output register when a newer one or the flush comes
// throughput: one frame at a time; the walk visits every key, a click event takes an extra step,
//   a held key past the repeat delay waits on the 32-step remainder unit and takes one more
//   step when it repeats, and output stalls hold the walk
// reset: async active low; held counters clear, registers take their defaults, block idles
module key_event_repeat_generator
    import kerg_pkg::*;
#(
    parameter int NUM_KEYS = DEF_NUM_KEYS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write port
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    // frame input channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [MASK_W-1:0]    held_keys,
    // event output channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [KEY_IDX_W-1:0] key_index,
    output logic [KIND_W-1:0]    event_kind,
    output logic                 last
);

    localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam logic [KEY_W-1:0] LAST_KEY = KEY_W'(NUM_KEYS - 1);

    // sequencer states
    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_EXAMINE = 6'b000010,
        ST_MOD     = 6'b000100,
        ST_REPEAT  = 6'b001000,
        ST_CLICK   = 6'b010000,
        ST_FLUSH   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [DATA_W-1:0] delay_reg;
    logic [DATA_W-1:0] pause_reg;
    logic [DATA_W-1:0] click_reg;
    logic [MASK_W-1:0] mask_reg;

    // frame and walk position
    logic [MASK_W-1:0] frame_reg;
    logic [KEY_W-1:0]  k_reg, k_next;

    // per-key held-frame counters, read and written at the walk position only
    logic [DATA_W-1:0] cnt_reg [NUM_KEYS];
    logic              cnt_we;
    logic [DATA_W-1:0] cnt_wdata;

    // one pending event holds back so the last one of a frame can be flagged
    logic                 pend_valid_reg;
    logic [KEY_IDX_W-1:0] pend_key_reg;
    ev_kind_t             pend_kind_reg;

    // output register
    logic                 out_valid_reg;
    logic [KEY_IDX_W-1:0] key_index_reg;
    logic [KIND_W-1:0]    event_kind_reg;
    logic                 last_reg;

    logic [31:0]          k_ext;
    logic                 key_live;
    logic [KEY_IDX_W-1:0] key_bit;
    logic                 held;
    logic                 masked;
    logic [DATA_W-1:0]    cur_cnt;
    logic                 cnt_zero;
    logic                 rep_gate;
    logic                 out_free;
    logic                 push_ok;
    logic                 push_go;
    ev_kind_t             push_kind;
    logic                 flush_go;
    logic                 adv;
    logic                 out_load;

    mod_req_t mod_req;
    mod_rsp_t mod_rsp;

    kerg_mod u_mod
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    // current key decode; keys past the input width are never held nor masked
    assign k_ext    = 32'(k_reg);
    assign key_live = (k_ext < IN_KEYS);
    assign key_bit  = k_ext[KEY_IDX_W-1:0];
    assign held     = key_live && frame_reg[key_bit];
    assign masked   = key_live && mask_reg[key_bit];
    assign cur_cnt  = cnt_reg[k_reg];
    assign cnt_zero = (cur_cnt == '0);

    // repeat is only worth a remainder test past a nonzero delay with a nonzero pause
    assign rep_gate = (delay_reg != '0) && (cur_cnt > delay_reg) && (pause_reg != '0);

    // an event can be pushed when the pending slot is empty or can move out now
    assign out_free = !out_valid_reg || !out_stall;
    assign push_ok  = !pend_valid_reg || out_free;

    always_comb
    begin
        state_next       = state_reg;
        k_next           = k_reg;
        cnt_we           = 1'b0;
        cnt_wdata        = cur_cnt + 1'b1;
        push_go          = 1'b0;
        push_kind        = EV_DOWN;
        flush_go         = 1'b0;
        adv              = 1'b0;
        mod_req.start    = 1'b0;
        mod_req.dividend = cur_cnt;
        mod_req.divisor  = pause_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    k_next     = '0;
                    state_next = ST_EXAMINE;
                end
            end
            ST_EXAMINE:
            begin
                if (masked)
                begin
                    adv = 1'b1;
                end
                else if (held)
                begin
                    if (cnt_zero)
                    begin
                        // fresh press
                        push_kind = EV_DOWN;
                        if (push_ok)
                        begin
                            push_go = 1'b1;
                            cnt_we  = 1'b1;
                            adv     = 1'b1;
                        end
                    end
                    else if (rep_gate)
                    begin
                        mod_req.start = 1'b1;
                        state_next    = ST_MOD;
                    end
                    else
                    begin
                        cnt_we = 1'b1;
                        adv    = 1'b1;
                    end
                end
                else if (!cnt_zero)
                begin
                    // release after hold, short holds also click
                    push_kind = EV_UP;
                    if (push_ok)
                    begin
                        push_go   = 1'b1;
                        cnt_we    = 1'b1;
                        cnt_wdata = '0;
                        if (cur_cnt < click_reg)
                        begin
                            state_next = ST_CLICK;
                        end
                        else
                        begin
                            adv = 1'b1;
                        end
                    end
                end
                else
                begin
                    adv = 1'b1;
                end
            end
            ST_MOD:
            begin
                if (mod_rsp.done)
                begin
                    if (mod_rsp.rem_zero)
                    begin
                        state_next = ST_REPEAT;
                    end
                    else
                    begin
                        cnt_we = 1'b1;
                        adv    = 1'b1;
                    end
                end
            end
            ST_REPEAT:
            begin
                push_kind = EV_REPEAT;
                if (push_ok)
                begin
                    push_go = 1'b1;
                    cnt_we  = 1'b1;
                    adv     = 1'b1;
                end
            end
            ST_CLICK:
            begin
                push_kind = EV_CLICK;
                if (push_ok)
                begin
                    push_go = 1'b1;
                    adv     = 1'b1;
                end
            end
            ST_FLUSH:
            begin
                // hand the held-back event out flagged as the frame's last
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    flush_go   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // step to the next key or finish the walk
        if (adv)
        begin
            if (k_reg == LAST_KEY)
            begin
                state_next = ST_FLUSH;
            end
            else
            begin
                k_next     = k_reg + 1'b1;
                state_next = ST_EXAMINE;
            end
        end
    end

    // pending event moves to the output register when a newer one arrives or at flush
    assign out_load = (push_go && pend_valid_reg) || flush_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            k_reg          <= '0;
            delay_reg      <= RST_REPEAT_DELAY;
            pause_reg      <= RST_REPEAT_PAUSE;
            click_reg      <= RST_CLICK_LIMIT;
            mask_reg       <= RST_IGNORE_MASK;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < NUM_KEYS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;

            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_REPEAT_DELAY: delay_reg <= cfg_data;
                    CFG_REPEAT_PAUSE: pause_reg <= cfg_data;
                    CFG_CLICK_LIMIT:  click_reg <= cfg_data;
                    CFG_IGNORE_MASK:  mask_reg  <= cfg_data[MASK_W-1:0];
                    default:          ;
                endcase
            end

            if (cnt_we)
            begin
                cnt_reg[k_reg] <= cnt_wdata;
            end

            if (push_go)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (flush_go)
            begin
                pend_valid_reg <= 1'b0;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            frame_reg <= held_keys;
        end
        if (push_go)
        begin
            pend_key_reg  <= key_bit;
            pend_kind_reg <= push_kind;
        end
        if (out_load)
        begin
            key_index_reg  <= pend_key_reg;
            event_kind_reg <= pend_kind_reg;
            last_reg       <= flush_go;
        end
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign key_index  = key_index_reg;
    assign event_kind = event_kind_reg;
    assign last       = last_reg;

    // a frame transaction always starts the walk at key zero
    a_walk_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == ST_EXAMINE && k_reg == '0)
        else $error("walk did not start at key zero");

    // every frame leaves nothing held back once idle
    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !pend_valid_reg)
        else $error("pending event left behind at idle");

    // the remainder test is always followed by waiting on it
    a_mod_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mod_req.start |=> state_reg == ST_MOD)
        else $error("remainder started without waiting for it");

    // flush only after the last key
    a_flush_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FLUSH |-> k_reg == LAST_KEY)
        else $error("flush before the walk finished");

endmodule
